@@ sv/ble_payload_utf8_classifier_macros.svh @@
// Assertion macros for the payload classifier.
// Used by the top level only; needs nothing else.
`ifndef BLE_PAYLOAD_UTF8_CLASSIFIER_MACROS_SVH
`define BLE_PAYLOAD_UTF8_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BPUC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPUC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bpuc_pkg.sv @@
// Types and constants for the payload classifier.
// No dependencies; imported by the top level.
package bpuc_pkg;

  localparam int CNT_W           = 10;
  localparam int COUNT_FIELD_MAX = 1023;
  localparam int MAX_PAYLOAD_DEF = 512;

  localparam logic [7:0] ASCII_MAX     = 8'h7F;
  localparam logic [7:0] LEAD2_MIN     = 8'hC2;
  localparam logic [7:0] LEAD2_MAX     = 8'hDF;
  localparam logic [7:0] LEAD3_MIN     = 8'hE0;
  localparam logic [7:0] LEAD3_MAX     = 8'hEF;
  localparam logic [7:0] LEAD3_SURR    = 8'hED;
  localparam logic [7:0] LEAD4_MIN     = 8'hF0;
  localparam logic [7:0] LEAD4_MAX     = 8'hF4;
  localparam logic [7:0] CONT_LIM_A0   = 8'hA0;
  localparam logic [7:0] CONT_LIM_90   = 8'h90;
  localparam logic [7:0] CONT_MASK     = 8'hC0;
  localparam logic [7:0] CONT_PATTERN  = 8'h80;

  // Binary tag "OWT"
  localparam logic [7:0] TAG_BYTE0 = 8'h4F;
  localparam logic [7:0] TAG_BYTE1 = 8'h57;
  localparam logic [7:0] TAG_BYTE2 = 8'h54;

  typedef enum logic [2:0] {
    RULE_NONE     = 3'd0,
    RULE_MIN_A0   = 3'd1,
    RULE_BELOW_A0 = 3'd2,
    RULE_MIN_90   = 3'd3,
    RULE_BELOW_90 = 3'd4
  } cont_rule_t;

  typedef enum logic [1:0] {
    VERDICT_TEXT_OK     = 2'd0,
    VERDICT_TEXT_BAD    = 2'd1,
    VERDICT_BIN_ROUTED  = 2'd2,
    VERDICT_BIN_DROPPED = 2'd3
  } verdict_t;

  function automatic logic [7:0] tag_byte(input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0:    b = TAG_BYTE0;
      2'd1:    b = TAG_BYTE1;
      2'd2:    b = TAG_BYTE2;
      default: b = TAG_BYTE2;
    endcase
    return b;
  endfunction

endpackage

@@ sv/ble_payload_utf8_classifier.sv @@
// Top level of the write-payload classifier: tag detection and strict UTF-8 check.
// Depends on bpuc_pkg and ble_payload_utf8_classifier_macros.svh.
//
// Usage:
//   in_*  : one payload byte per transfer in in_tdata[7:0], in_tlast on the final byte.
//   out_* : one transfer per payload, issued for the final byte only.
//           out_tdata[1:0] is the verdict (text ok, text bad, binary routed,
//           binary dropped), out_tdata[11:2] the byte count, saturating.
//   cfg_* : cfg_wr_en writes cfg_wr_data into the binary route enable; write
//           it only while no payload is in flight.
// A byte lands in an input register and is evaluated there; on the final
// byte the verdict is loaded into the result register, which drives out_tvalid.
// Throughput is one byte per cycle, save for a final byte held by the stall
// below, set by the state update between the input register and the result register.
// Stall: while out_tvalid waits on out_tready the block keeps taking non-final
// bytes; a second final byte waits in the input register, which then holds
// in_tready low until the result slot frees.
// Reset (rst_n low, synchronous) empties both registers, clears the per-payload
// state and turns binary routing off.
`include "ble_payload_utf8_classifier_macros.svh"

module ble_payload_utf8_classifier
  import bpuc_pkg::*;
#(
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] payload_byte
  input  logic        in_tlast,   // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] verdict, [11:2] byte_count, [15:12] zero
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data // binary_route_enable
);

  localparam int CountCapInt = (MAX_PAYLOAD_BYTES > COUNT_FIELD_MAX) ?
                               COUNT_FIELD_MAX : MAX_PAYLOAD_BYTES;
  localparam logic [CNT_W-1:0] CountCap = CNT_W'(CountCapInt);

  // Configuration
  logic route_en_r;

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Per-payload state
  logic [1:0]       pos_r,   pos_nxt;
  logic             match_r, match_nxt;
  logic [1:0]       pend_r,  pend_nxt;
  cont_rule_t       rule_r,  rule_nxt;
  logic             inv_r,   inv_nxt;
  logic [CNT_W-1:0] len_r,   len_nxt;

  // Result register
  logic             out_valid_r;
  verdict_t         verdict_r, verdict_nxt;
  logic [CNT_W-1:0] count_r;

  logic out_free;
  logic s1_adv;
  logic cont_ok;

  // Result slot is free when empty or being drained this cycle.
  assign out_free  = !out_valid_r || out_tready;
  // A non-final byte never needs the result slot.
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  // Continuation byte check, including the second-byte range limits.
  always_comb begin
    cont_ok = (s1_byte_r & CONT_MASK) == CONT_PATTERN;
    unique case (rule_r)
      RULE_MIN_A0:   cont_ok = cont_ok && (s1_byte_r >= CONT_LIM_A0);
      RULE_BELOW_A0: cont_ok = cont_ok && (s1_byte_r <  CONT_LIM_A0);
      RULE_MIN_90:   cont_ok = cont_ok && (s1_byte_r >= CONT_LIM_90);
      RULE_BELOW_90: cont_ok = cont_ok && (s1_byte_r <  CONT_LIM_90);
      default:       cont_ok = cont_ok;
    endcase
  end

  // State update for the byte in the input register.
  always_comb begin
    len_nxt   = (len_r < CountCap) ? len_r + CNT_W'(1) : len_r;

    pos_nxt   = pos_r;
    match_nxt = match_r;
    if (pos_r < 2'd3) begin
      if (s1_byte_r != tag_byte(pos_r)) begin
        match_nxt = 1'b0;
      end
      pos_nxt = pos_r + 2'd1;
    end

    pend_nxt = pend_r;
    rule_nxt = rule_r;
    inv_nxt  = inv_r;
    if (pend_r == 2'd0) begin
      priority if (s1_byte_r <= ASCII_MAX) begin
        pend_nxt = 2'd0;
      end else if (s1_byte_r >= LEAD2_MIN && s1_byte_r <= LEAD2_MAX) begin
        pend_nxt = 2'd1;
        rule_nxt = RULE_NONE;
      end else if (s1_byte_r >= LEAD3_MIN && s1_byte_r <= LEAD3_MAX) begin
        pend_nxt = 2'd2;
        rule_nxt = (s1_byte_r == LEAD3_MIN)  ? RULE_MIN_A0 :
                   (s1_byte_r == LEAD3_SURR) ? RULE_BELOW_A0 : RULE_NONE;
      end else if (s1_byte_r >= LEAD4_MIN && s1_byte_r <= LEAD4_MAX) begin
        pend_nxt = 2'd3;
        rule_nxt = (s1_byte_r == LEAD4_MIN) ? RULE_MIN_90 :
                   (s1_byte_r == LEAD4_MAX) ? RULE_BELOW_90 : RULE_NONE;
      end else begin
        // bad lead: flag and drop sequence tracking
        inv_nxt  = 1'b1;
        pend_nxt = 2'd0;
        rule_nxt = RULE_NONE;
      end
    end else if (cont_ok) begin
      pend_nxt = pend_r - 2'd1;
      rule_nxt = RULE_NONE;
    end else begin
      inv_nxt  = 1'b1;
      pend_nxt = 2'd0;
      rule_nxt = RULE_NONE;
    end

    // Verdict from the state after this byte; tag wins over the text check.
    priority if (pos_nxt == 2'd3 && match_nxt) begin
      verdict_nxt = route_en_r ? VERDICT_BIN_ROUTED : VERDICT_BIN_DROPPED;
    end else if (inv_nxt || pend_nxt != 2'd0) begin
      verdict_nxt = VERDICT_TEXT_BAD;
    end else begin
      verdict_nxt = VERDICT_TEXT_OK;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      route_en_r <= cfg_wr_data;
    end
  end

  // Input register: load on every accepted transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // Per-payload state: advance on each evaluated byte, clear after the final one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 2'd0;
      match_r <= 1'b1;
      pend_r  <= 2'd0;
      rule_r  <= RULE_NONE;
      inv_r   <= 1'b0;
      len_r   <= '0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        pos_r   <= 2'd0;
        match_r <= 1'b1;
        pend_r  <= 2'd0;
        rule_r  <= RULE_NONE;
        inv_r   <= 1'b0;
        len_r   <= '0;
      end else begin
        pos_r   <= pos_nxt;
        match_r <= match_nxt;
        pend_r  <= pend_nxt;
        rule_r  <= rule_nxt;
        inv_r   <= inv_nxt;
        len_r   <= len_nxt;
      end
    end
  end

  // Result register: fill on a final byte, drop on the outgoing transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      verdict_r <= verdict_nxt;
      count_r   <= len_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, count_r, verdict_r};

  // Checks
  `BPUC_ASSERT_NEXT(a_final_gives_result, clk, rst_n, s1_adv && s1_last_r, out_valid_r, "final byte produced no result")
  `BPUC_ASSERT_NOW(a_rule_needs_pending, clk, rst_n, rule_r != RULE_NONE, pend_r != 2'd0, "range rule set with no continuation owed")
  `BPUC_ASSERT_NOW(a_fresh_payload_clean, clk, rst_n, pos_r == 2'd0, len_r == '0 && match_r, "tag position and length out of step")
  `BPUC_ASSERT_NOW(a_binary_min_len, clk, rst_n, out_valid_r && (verdict_r == VERDICT_BIN_ROUTED || verdict_r == VERDICT_BIN_DROPPED), count_r >= CNT_W'(3), "binary verdict on a payload under three bytes")

endmodule

@@ verif/payload_verdict_checker.sv @@
// Checker for the payload classifier: watches the byte, result and configuration ports,
// predicts the verdict and byte count of each payload and compares them on arrival.
// Depends on bpuc_pkg for the verdict and continuation-rule types and the byte constants.
module payload_verdict_checker
  import bpuc_pkg::*;
#(
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  output int unsigned err_count,
  output int unsigned pending_count,
  output int unsigned checked_count
);

  localparam int COUNT_CAP =
    (MAX_PAYLOAD_BYTES > COUNT_FIELD_MAX) ? COUNT_FIELD_MAX : MAX_PAYLOAD_BYTES;

  typedef struct packed {
    verdict_t             verdict;
    logic [CNT_W-1:0]     count;
  } payload_result_t;

  payload_result_t verdicts_due[$];
  payload_result_t oldest;

  // predicted block state
  logic             route_en;
  logic [1:0]       tag_pos;
  logic             tag_ok;
  logic [1:0]       owed;
  cont_rule_t       rule;
  logic             utf_err;
  logic [CNT_W-1:0] len_cnt;

  int unsigned errors  = 0;
  int unsigned checked = 0;

  task automatic clear_payload_state();
    tag_pos = 2'd0;
    tag_ok  = 1'b1;
    owed    = 2'd0;
    rule    = RULE_NONE;
    utf_err = 1'b0;
    len_cnt = '0;
  endtask

  // Error is sticky; drop any sequence in progress.
  task automatic break_sequence();
    utf_err = 1'b1;
    owed    = 2'd0;
    rule    = RULE_NONE;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic fin);
    logic [7:0]      want;
    logic            ok;
    payload_result_t res;
    if (len_cnt < COUNT_CAP) len_cnt++;
    if (tag_pos != 2'd3) begin
      case (tag_pos)
        2'd0:    want = TAG_BYTE0;
        2'd1:    want = TAG_BYTE1;
        default: want = TAG_BYTE2;
      endcase
      if (b != want) tag_ok = 1'b0;
      tag_pos++;
    end
    if (owed == 2'd0) begin
      if (b <= ASCII_MAX) begin
        // plain ASCII, nothing owed
      end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
        owed = 2'd1;
        rule = RULE_NONE;
      end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
        owed = 2'd2;
        rule = (b == LEAD3_MIN)  ? RULE_MIN_A0 :
               (b == LEAD3_SURR) ? RULE_BELOW_A0 : RULE_NONE;
      end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
        owed = 2'd3;
        rule = (b == LEAD4_MIN) ? RULE_MIN_90 :
               (b == LEAD4_MAX) ? RULE_BELOW_90 : RULE_NONE;
      end else begin
        break_sequence();
      end
    end else begin
      ok = ((b & CONT_MASK) == CONT_PATTERN);
      case (rule)
        RULE_MIN_A0:   ok = ok && (b >= CONT_LIM_A0);
        RULE_BELOW_A0: ok = ok && (b <  CONT_LIM_A0);
        RULE_MIN_90:   ok = ok && (b >= CONT_LIM_90);
        RULE_BELOW_90: ok = ok && (b <  CONT_LIM_90);
        default: ;
      endcase
      if (!ok) begin
        break_sequence();
      end else begin
        owed--;
        rule = RULE_NONE;
      end
    end
    if (fin) begin
      if (tag_pos == 2'd3 && tag_ok)
        res.verdict = route_en ? VERDICT_BIN_ROUTED : VERDICT_BIN_DROPPED;
      else if (utf_err || owed != 2'd0)
        res.verdict = VERDICT_TEXT_BAD;
      else
        res.verdict = VERDICT_TEXT_OK;
      res.count = len_cnt;
      verdicts_due.push_back(res);
      clear_payload_state();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      route_en = 1'b0;
      clear_payload_state();
      verdicts_due.delete();
    end else begin
      if (cfg_wr_en) route_en = cfg_wr_data;
      if (in_tvalid && in_tready) absorb_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (verdicts_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got verdict %0d count %0d",
                   $time, out_tdata[1:0], out_tdata[11:2]);
        end else begin
          oldest = verdicts_due.pop_front();
          checked++;
          if (out_tdata[1:0] != oldest.verdict) begin
            errors++;
            $display("%0t: verdict mismatch, expected %0d, got %0d",
                     $time, oldest.verdict, out_tdata[1:0]);
          end
          if (out_tdata[11:2] != oldest.count) begin
            errors++;
            $display("%0t: byte count mismatch, expected %0d, got %0d",
                     $time, oldest.count, out_tdata[11:2]);
          end
        end
      end
    end
    err_count     <= errors;
    pending_count <= verdicts_due.size();
    checked_count <= checked;
  end

endmodule

@@ verif/testbench.sv @@
// Top of the payload classifier testbench: clock, reset, byte stimulus, result
// back-pressure, configuration writes and the final verdict.
// Depends on ble_payload_utf8_classifier, bpuc_pkg and payload_verdict_checker.
module testbench;

  // Roughly how many payload bytes to push through in total.
  localparam int unsigned ITEM_TARGET = 1250;
  // Run stops here no matter what; the slowest legal run is far below this.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Long payload length: past the 512-byte saturation point of the count.
  localparam int unsigned LONG_LEN    = 515;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'h00;
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;

  int unsigned checker_errors;
  int unsigned results_due;
  int unsigned results_checked;

  int unsigned cycles        = 0;
  int unsigned bytes_sent    = 0;
  int unsigned payloads_sent = 0;
  int unsigned config_writes = 0;
  int          in_calm       = 0;
  int          out_calm      = 0;

  // Bytes of the payload being built, sent first to last.
  logic [7:0] pay[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ble_payload_utf8_classifier dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  payload_verdict_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .err_count     (checker_errors),
    .pending_count (results_due),
    .checked_count (results_checked)
  );

  // Hard stop: a hang anywhere in the block ends up here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycles, results_due);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Idle cycles ahead of the next transfer on one side. Often none, otherwise
  // drawn at random, with occasional stretches of back-to-back transfers.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Result side: stall for a random number of cycles before each transfer.
  // Lower tready only when a stall is drawn, so it never toggles within a step.
  initial begin : result_sink
    int n;
    @(posedge clk);
    forever begin
      n = draw_wait(out_calm);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Drive one byte and hold it until the block takes it. During a gap the
  // data lines carry junk so that nothing relies on them while tvalid is low.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int n;
    n = draw_wait(in_calm);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tlast  <= 1'($urandom);
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_payload();
    foreach (pay[i]) send_byte(pay[i], i == pay.size() - 1);
    payloads_sent++;
  endtask

  // Let the checker count the last transfer, drain every pending result,
  // then write the route enable while nothing is in flight.
  task automatic configure_route(input logic route);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= route;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    config_writes++;
  endtask

  // Append one code point as well-formed UTF-8.
  task automatic push_char(input int unsigned cp);
    if (cp < 'h80) begin
      pay.push_back(8'(cp));
    end else if (cp < 'h800) begin
      pay.push_back(8'('hC0 | (cp >> 6)));
      pay.push_back(8'('h80 | (cp & 'h3F)));
    end else if (cp < 'h10000) begin
      pay.push_back(8'('hE0 | (cp >> 12)));
      pay.push_back(8'('h80 | ((cp >> 6) & 'h3F)));
      pay.push_back(8'('h80 | (cp & 'h3F)));
    end else begin
      pay.push_back(8'('hF0 | (cp >> 18)));
      pay.push_back(8'('h80 | ((cp >> 12) & 'h3F)));
      pay.push_back(8'('h80 | ((cp >> 6) & 'h3F)));
      pay.push_back(8'('h80 | (cp & 'h3F)));
    end
  endtask

  // Random scalar value, evenly over the four encoded lengths and leaning on
  // the range boundaries, which sit right at the E0/ED/F0/F4 second-byte limits.
  function automatic int unsigned pick_cp();
    int unsigned cp;
    logic        at_bound;
    at_bound = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 3))
      0: cp = at_bound ? ($urandom_range(0, 1) ? 'h7F : 'h0) : $urandom_range(0, 'h7F);
      1: cp = at_bound ? ($urandom_range(0, 1) ? 'h7FF : 'h80) : $urandom_range('h80, 'h7FF);
      2: begin
        if (at_bound) begin
          case ($urandom_range(0, 3))
            0:       cp = 'h800;
            1:       cp = 'hD7FF;
            2:       cp = 'hE000;
            default: cp = 'hFFFF;
          endcase
        end else begin
          cp = $urandom_range('h800, 'hFFFF);
        end
        // fold surrogates down into the plain three-byte range
        if (cp >= 'hD800 && cp <= 'hDFFF) cp -= 'h800;
      end
      default: cp = at_bound ? ($urandom_range(0, 1) ? 'h10FFFF : 'h10000)
                             : $urandom_range('h10000, 'h10FFFF);
    endcase
    return cp;
  endfunction

  task automatic add_text(input int n);
    repeat (n) push_char(pick_cp());
  endtask

  task automatic add_tag();
    pay.push_back(8'h4F);
    pay.push_back(8'h57);
    pay.push_back(8'h54);
  endtask

  // One random payload. Most are well formed (valid text, tagged blobs), the
  // rest carry a corrupted byte, a cut-off sequence, a broken tag or noise.
  task automatic build_payload();
    int          pos;
    int          keep;
    logic [7:0]  bad;
    pay.delete();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: add_text($urandom_range(1, 6));
      4: begin
        add_text($urandom_range(1, 6));
        pos = $urandom_range(0, pay.size() - 1);
        case ($urandom_range(0, 2))
          0:       bad = 8'($urandom);
          1:       bad = 8'($urandom_range('h80, 'hBF));
          default: bad = $urandom_range(0, 1) ? 8'($urandom_range('hC0, 'hC1))
                                              : 8'($urandom_range('hF5, 'hFF));
        endcase
        pay[pos] = bad;
      end
      5: begin
        // end in the middle of a multi-byte sequence
        add_text($urandom_range(0, 4));
        push_char($urandom_range('h80, 'hD7FF));
        pay.pop_back();
      end
      6, 7: begin
        add_tag();
        if ($urandom_range(0, 1)) add_text($urandom_range(0, 4));
        else repeat ($urandom_range(0, 8)) pay.push_back(8'($urandom));
      end
      8: begin
        add_tag();
        if ($urandom_range(0, 1)) begin
          // tag cut short by the end of the payload
          keep = $urandom_range(1, 2);
          while (pay.size() > keep) pay.pop_back();
        end else begin
          pay[$urandom_range(0, 2)] ^= 8'(1 << $urandom_range(0, 7));
          add_text($urandom_range(0, 3));
        end
      end
      default: repeat ($urandom_range(1, 10)) pay.push_back(8'($urandom));
    endcase
  endtask

  initial begin : stimulus
    int   phase;
    logic route;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, route enable still at its reset value (off).
    pay = '{8'h4F, 8'h57, 8'h54};              send_payload();  // tag alone: dropped
    pay = '{8'h4F, 8'h57};                     send_payload();  // tag too short: text
    pay = '{8'h00};                            send_payload();  // lowest byte
    pay = '{8'hFF};                            send_payload();  // highest byte, bad lead
    pay = '{8'hF5};                            send_payload();  // first lead past F4
    pay = '{8'hC0, 8'h80};                     send_payload();  // overlong two-byte
    pay = '{8'hE0, 8'h9F, 8'h80};              send_payload();  // overlong three-byte
    pay = '{8'hED, 8'hA0, 8'h80};              send_payload();  // surrogate
    pay = '{8'hF4, 8'h90, 8'h80, 8'h80};       send_payload();  // beyond 10FFFF
    pay = '{8'hE2, 8'h82};                     send_payload();  // truncated at the end

    // Random part in phases; the route enable changes only between phases,
    // first on, then off, then at random.
    phase = 0;
    while (bytes_sent < ITEM_TARGET) begin
      route = (phase == 0) ? 1'b1 : (phase == 1) ? 1'b0 : 1'($urandom_range(0, 1));
      configure_route(route);
      if (phase == 3) begin
        // saturate the count; sometimes spoil the very last byte
        pay.delete();
        while (pay.size() < LONG_LEN) push_char(pick_cp());
        if ($urandom_range(0, 1)) pay.push_back(8'hFF);
        send_payload();
      end
      repeat ($urandom_range(4, 12)) begin
        build_payload();
        send_payload();
      end
      phase++;
    end

    // Wind down: wait out every result, then keep the inputs quiet to catch strays.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d payloads (%0d bytes) in %0d phases, %0d route enable writes",
             payloads_sent, bytes_sent, phase, config_writes);
    $display("Checked %0d verdicts in %0d cycles", results_checked, cycles);
    if (checker_errors == 0 && results_due == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
